// ===== rtl/bsd_pkg.sv =====
// Types and opcode constants for the branch successor decoder.
// No dependencies; used by bsd_decode and branch_successor_decoder.
package bsd_pkg;

  localparam logic REQ_DECODE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  localparam logic [7:0] OP_J24_A  = 8'h1D;
  localparam logic [7:0] OP_J24_B  = 8'h5D;
  localparam logic [7:0] OP_J24_C  = 8'h6D;
  localparam logic [7:0] OP_J24_D  = 8'h61;
  localparam logic [7:0] OP_D15_A  = 8'h1F;
  localparam logic [7:0] OP_D15_B  = 8'h3F;
  localparam logic [7:0] OP_D15_C  = 8'h5F;
  localparam logic [7:0] OP_D15_D  = 8'h7F;
  localparam logic [7:0] OP_D15_E  = 8'h9F;
  localparam logic [7:0] OP_D15_F  = 8'hBF;
  localparam logic [7:0] OP_D15_G  = 8'hDF;
  localparam logic [7:0] OP_D15_H  = 8'hEF;
  localparam logic [7:0] OP_D15_I  = 8'hFF;
  localparam logic [7:0] OP_D15_J  = 8'h6F;
  localparam logic [7:0] OP_JI32   = 8'h2D;
  localparam logic [7:0] OP_D8_A   = 8'h3C;
  localparam logic [7:0] OP_D8_B   = 8'hEE;
  localparam logic [7:0] OP_D8_C   = 8'hF6;
  localparam logic [7:0] OP_D8_D   = 8'h6E;
  localparam logic [7:0] OP_D8_E   = 8'h76;
  localparam logic [7:0] OP_D8_F   = 8'h5C;
  localparam logic [7:0] OP_D4_A   = 8'h3E;
  localparam logic [7:0] OP_D4_B   = 8'hBE;
  localparam logic [7:0] OP_D4_C   = 8'h7E;
  localparam logic [7:0] OP_D4_D   = 8'hFE;
  localparam logic [7:0] OP_D4_E   = 8'hF2;
  localparam logic [7:0] OP_D4_F   = 8'h7C;
  localparam logic [7:0] OP_JI16   = 8'hDC;
  localparam logic [7:0] OP_SYS16  = 8'h00;
  localparam logic [7:0] SYS_RET   = 8'h90;
  localparam logic [3:0] RA_INDEX  = 4'd11;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DIRECT,
    KIND_REG
  } tgt_kind_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] pc;
    logic [31:0] instr_word;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] seq_pc;
    logic [31:0] branch_target;
    logic        has_target;
    logic        is_long;
  } out_word_t;

  typedef struct packed {
    tgt_kind_t   kind;
    logic        is_long;
    logic [31:0] seq_pc;
    logic [31:0] direct_tgt;
    logic [3:0]  reg_idx;
  } dec_t;

endpackage

// ===== rtl/bsd_decode.sv =====
// Opcode decode: width, sequential successor, direct target and register index.
// Depends on bsd_pkg.
module bsd_decode (
  input  logic [31:0]  pc,
  input  logic [31:0]  instr_word,
  output bsd_pkg::dec_t dec
);

  logic [7:0]  op;
  logic [31:0] disp;

  assign op = instr_word[7:0];

  always_comb begin
    dec.kind         = bsd_pkg::KIND_NONE;
    dec.is_long      = op[0];
    dec.seq_pc       = pc + (op[0] ? 32'd4 : 32'd2);
    dec.reg_idx      = instr_word[11:8];
    disp             = '0;
    unique case (op) inside
      bsd_pkg::OP_J24_A, bsd_pkg::OP_J24_B, bsd_pkg::OP_J24_C, bsd_pkg::OP_J24_D: begin
        disp     = {{7{instr_word[15]}}, instr_word[15:8], instr_word[31:16], 1'b0};
        dec.kind = bsd_pkg::KIND_DIRECT;
      end
      bsd_pkg::OP_D15_A, bsd_pkg::OP_D15_B, bsd_pkg::OP_D15_C, bsd_pkg::OP_D15_D,
      bsd_pkg::OP_D15_E, bsd_pkg::OP_D15_F, bsd_pkg::OP_D15_G, bsd_pkg::OP_D15_H,
      bsd_pkg::OP_D15_I, bsd_pkg::OP_D15_J: begin
        disp     = {{16{instr_word[30]}}, instr_word[30:16], 1'b0};
        dec.kind = bsd_pkg::KIND_DIRECT;
      end
      bsd_pkg::OP_D8_A, bsd_pkg::OP_D8_B, bsd_pkg::OP_D8_C, bsd_pkg::OP_D8_D,
      bsd_pkg::OP_D8_E, bsd_pkg::OP_D8_F: begin
        disp     = {{23{instr_word[15]}}, instr_word[15:8], 1'b0};
        dec.kind = bsd_pkg::KIND_DIRECT;
      end
      bsd_pkg::OP_D4_A, bsd_pkg::OP_D4_B, bsd_pkg::OP_D4_C, bsd_pkg::OP_D4_D,
      bsd_pkg::OP_D4_E, bsd_pkg::OP_D4_F: begin
        disp     = {27'd0, instr_word[11:8], 1'b0};
        dec.kind = bsd_pkg::KIND_DIRECT;
      end
      bsd_pkg::OP_JI32, bsd_pkg::OP_JI16: begin
        dec.kind = bsd_pkg::KIND_REG;
      end
      bsd_pkg::OP_SYS16: begin
        if (instr_word[15:8] == bsd_pkg::SYS_RET) begin
          dec.kind    = bsd_pkg::KIND_REG;
          dec.reg_idx = bsd_pkg::RA_INDEX;
        end
      end
      default: begin
        dec.kind = bsd_pkg::KIND_NONE;
      end
    endcase
    dec.direct_tgt = pc + disp;
  end

endmodule

// ===== rtl/bsd_areg.sv =====
// Address register file: 16 x 32 synchronous memory with a registered read.
// Per-entry valid flops make unwritten entries read as zero after reset.
// No dependencies.
module bsd_areg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic        rd_en,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [16];
  logic [15:0] vld_r;
  logic [31:0] rd_data_r;
  logic        rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : 32'd0;

endmodule

// ===== rtl/branch_successor_decoder.sv =====
// Branch successor decoder top: decode stage, register file read, output register.
// Depends on bsd_pkg, bsd_decode, bsd_areg.
//
//   channel | direction | handshake              | word
//   in_     | input     | in_valid / in_stall    | bsd_pkg::in_word_t
//   out_    | output    | out_valid / out_stall  | bsd_pkg::out_word_t
//
// One word accepted per cycle while in_stall is low; a decode word is registered in
// the read stage on acceptance and moves to the out_ register when that register
// is empty or out_stall is low, which raises out_valid. Load words give no output
// and write the register file at acceptance.
// Reset (rst_n, synchronous) empties the pipe and marks all registers as zero.
// in_stall is high only when the read stage and the output register are both full
// and out_stall is high.
module branch_successor_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bsd_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output bsd_pkg::out_word_t out_word
);

  bsd_pkg::dec_t      dec;
  bsd_pkg::dec_t      s1_r;
  bsd_pkg::dec_t      s1_nxt;
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  bsd_pkg::out_word_t out_word_r;
  bsd_pkg::out_word_t out_word_nxt;
  logic               out_ready;
  logic               in_acc;
  logic               dec_acc;
  logic               load_acc;
  logic [31:0]        rd_data;

  bsd_decode u_decode (
    .pc         (in_word.pc),
    .instr_word (in_word.instr_word),
    .dec        (dec)
  );

  bsd_areg u_areg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_acc),
    .wr_addr (in_word.reg_index),
    .wr_data (in_word.reg_value),
    .rd_en   (dec_acc),
    .rd_addr (dec.reg_idx),
    .rd_data (rd_data)
  );

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_acc    = in_valid && !in_stall;
  assign dec_acc   = in_acc && (in_word.req_type == bsd_pkg::REQ_DECODE);
  assign load_acc  = in_acc && (in_word.req_type == bsd_pkg::REQ_LOAD);

  always_comb begin
    s1_nxt        = s1_r;
    s1_valid_nxt  = s1_valid_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    if (!in_stall) begin
      s1_nxt       = dec;
      s1_valid_nxt = dec_acc;
    end
    if (out_ready) begin
      out_valid_nxt              = s1_valid_r;
      out_word_nxt.seq_pc        = s1_r.seq_pc;
      out_word_nxt.is_long       = s1_r.is_long;
      unique case (s1_r.kind)
        bsd_pkg::KIND_DIRECT: begin
          out_word_nxt.branch_target = s1_r.direct_tgt;
          out_word_nxt.has_target    = 1'b1;
        end
        bsd_pkg::KIND_REG: begin
          out_word_nxt.branch_target = rd_data;
          out_word_nxt.has_target    = 1'b1;
        end
        default: begin
          out_word_nxt.branch_target = 32'd0;
          out_word_nxt.has_target    = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall with empty read stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_ready) |=> (s1_valid_r && $stable(s1_r)))
    else $error("read stage changed while blocked");

  a_tgt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.has_target) |-> (out_word_r.branch_target == 32'd0))
    else $error("nonzero target without has_target");

  a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (load_acc && !s1_valid_r) |=> !s1_valid_r)
    else $error("load word entered decode pipe");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipe not empty after reset");
`endif

endmodule
